// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that check themselves.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define NSTA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define NSTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/nsta_pkg.sv =====
// Types and codes for the nested scope time accounting block.
// No dependencies.
package nsta_pkg;

	localparam logic [1:0] OP_ENTER = 2'd0;
	localparam logic [1:0] OP_EXIT  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  anchor_sel;
		logic [63:0] timestamp;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  anchor_out;
		logic [63:0] elapsed_out;
		logic [63:0] inclusive_out;
		logic [63:0] exclusive_out;
		logic [63:0] hits_out;
	} rsp_t;

	// one anchor table entry
	typedef struct packed {
		logic [63:0] incl;
		logic [63:0] excl;
		logic [63:0] hits;
	} ctr_t;

	// one frame stack entry
	typedef struct packed {
		logic [7:0]  anchor;
		logic [7:0]  parent;
		logic [63:0] start;
		logic [63:0] saved;
	} frame_t;

endpackage

// ===== hw/rtl/nsta_anchor_tbl.sv =====
// Anchor counter table: simple dual-port RAM, one write and one registered read.
// Depends on nsta_pkg.
module nsta_anchor_tbl #(
	parameter int NUM_ANCHORS = 256,
	localparam int AW = $clog2(NUM_ANCHORS)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  nsta_pkg::ctr_t  wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output nsta_pkg::ctr_t  rdata
);
	import nsta_pkg::*;

	ctr_t mem [NUM_ANCHORS];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/nsta_frame_stack.sv =====
// Frame stack storage: simple dual-port RAM holding one frame per nesting level.
// Depends on nsta_pkg.
module nsta_frame_stack #(
	parameter int STACK_DEPTH = 32,
	localparam int FW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [FW-1:0]    waddr,
	input  nsta_pkg::frame_t wdata,
	input  logic             re,
	input  logic [FW-1:0]    raddr,
	output nsta_pkg::frame_t rdata
);
	import nsta_pkg::*;

	frame_t mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/nested_scope_time_accounting.sv =====
// Hardware scope profiler. Each command word is enter (anchor + timestamp), exit
// (timestamp) or read (anchor); each one yields exactly one response word with the
// status, the anchor touched, the elapsed ticks of an exit and the anchor's
// inclusive, exclusive and hit counters after the operation. Commands run one at a
// time. Enter and read load the response register in their own state from the
// registered anchor read; a successful exit steps through frame pop, parent
// read-modify-write and anchor read-modify-write, all through the single write
// port of the anchor table, and responds from the last step; an exit on an empty
// stack responds from its first step. The responding step waits while the
// output register is full. A new command is taken while the previous response
// still waits in the output register. After reset the anchor table is zeroed by
// a clearing pass over all NUM_ANCHORS entries, during which cmd_ready stays
// low. Anchor indices are taken modulo NUM_ANCHORS; enter on a full stack
// (STACK_DEPTH frames) reports status 1 and changes nothing; exit on an empty
// stack reports the root anchor with status 2. Exclusive totals wrap modulo 2^64.
// Depends on nsta_pkg, nsta_anchor_tbl, nsta_frame_stack, assert_macros.svh.
`include "assert_macros.svh"

module nested_scope_time_accounting #(
	parameter int NUM_ANCHORS = 256,
	parameter int STACK_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  nsta_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output nsta_pkg::rsp_t rsp
);
	import nsta_pkg::*;

	localparam int AW = $clog2(NUM_ANCHORS);
	localparam int FW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LW = $clog2(STACK_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_CLR  = 3'd0;   // zeroing the anchor table
	localparam logic [2:0] S_IDLE = 3'd1;   // waiting for a command word
	localparam logic [2:0] S_ENT  = 3'd2;   // enter: push frame unless full, respond
	localparam logic [2:0] S_RD   = 3'd3;   // read: respond
	localparam logic [2:0] S_X1   = 3'd4;   // exit: frame data back, fetch parent, or respond if empty
	localparam logic [2:0] S_X2   = 3'd5;   // exit: update parent, fetch anchor
	localparam logic [2:0] S_X3   = 3'd6;   // exit: update anchor, respond

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [LW-1:0] level_q;
	logic [7:0]    cur_parent_q;
	logic          out_valid_q;
	rsp_t          out_q;

	// per-command working registers
	logic [7:0]    sel_q;
	logic [63:0]   ts_q;
	logic [7:0]    fa_q;
	logic [7:0]    fp_q;
	logic [63:0]   elapsed_q;
	logic [63:0]   saved_q;

	// anchor_sel modulo NUM_ANCHORS, resolved at elaboration
	logic [7:0] sel_mod_tbl [256];
	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign sel_mod_tbl[g] = 8'(g % NUM_ANCHORS);
	end

	logic [7:0] sel_mod;
	assign sel_mod = sel_mod_tbl[cmd.anchor_sel];

	// memory ports
	logic          a_we, a_re;
	logic [AW-1:0] a_waddr, a_raddr;
	ctr_t          a_wdata, a_rdata, a_upd;
	logic          f_we, f_re;
	logic [FW-1:0] f_waddr, f_raddr;
	frame_t        f_wdata, f_rdata;

	logic          accept, out_free, finish, full, empty;
	logic [63:0]   excl_new;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign full      = (level_q == LW'(STACK_DEPTH));
	assign empty     = (level_q == '0);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// responding states complete only when the output register can take the word
	assign finish = out_free &&
		(state_q == S_ENT || state_q == S_RD || state_q == S_X3 ||
		(state_q == S_X1 && empty));

	// parent and anchor equal: the subtract and add cancel
	assign excl_new = (fa_q == fp_q) ? a_rdata.excl : a_rdata.excl + elapsed_q;
	assign a_upd = '{incl: saved_q + elapsed_q, excl: excl_new, hits: a_rdata.hits + 64'd1};

	always_comb begin
		a_we    = 1'b0;
		a_waddr = clr_q;
		a_wdata = '0;
		a_re    = 1'b0;
		a_raddr = (cmd.op == OP_EXIT) ? '0 : AW'(sel_mod);
		unique case (state_q)
			S_CLR: begin
				a_we = 1'b1;
			end
			S_IDLE: begin
				a_re = cmd_valid;
			end
			S_X1: begin
				a_re    = !empty;
				a_raddr = AW'(f_rdata.parent);
			end
			S_X2: begin
				a_we    = 1'b1;
				a_waddr = AW'(fp_q);
				a_wdata = '{incl: a_rdata.incl, excl: a_rdata.excl - elapsed_q,
					hits: a_rdata.hits};
				a_re    = 1'b1;
				a_raddr = AW'(fa_q);
			end
			S_X3: begin
				a_we    = out_free;
				a_waddr = AW'(fa_q);
				a_wdata = a_upd;
			end
			default: ;
		endcase
	end

	// frame pushes only in the enter state, pops read at accept
	assign f_we    = (state_q == S_ENT) && out_free && !full;
	assign f_waddr = FW'(level_q);
	assign f_wdata = '{anchor: sel_q, parent: cur_parent_q, start: ts_q, saved: a_rdata.incl};
	assign f_re    = accept;
	assign f_raddr = FW'(level_q - 1'b1);

	nsta_anchor_tbl #(.NUM_ANCHORS(NUM_ANCHORS)) u_anchor_tbl (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	nsta_frame_stack #(.STACK_DEPTH(STACK_DEPTH)) u_frame_stack (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			level_q      <= '0;
			cur_parent_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_ANCHORS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_ENTER: state_q <= S_ENT;
							OP_EXIT:  state_q <= S_X1;
							default:  state_q <= S_RD;
						endcase
					end
				end
				S_ENT: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (!full) begin
							level_q      <= level_q + 1'b1;
							cur_parent_q <= sel_q;
						end
					end
				end
				S_RD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_X1: begin
					if (!empty) begin
						level_q      <= level_q - 1'b1;
						cur_parent_q <= f_rdata.parent;
						state_q      <= S_X2;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_X2: begin
					state_q <= S_X3;
				end
				S_X3: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q <= sel_mod;
			ts_q  <= cmd.timestamp;
		end
		if (state_q == S_X1) begin
			fa_q      <= f_rdata.anchor;
			fp_q      <= f_rdata.parent;
			saved_q   <= f_rdata.saved;
			elapsed_q <= ts_q - f_rdata.start;
		end
		if (finish) begin
			out_q.status        <= ST_OK;
			out_q.anchor_out    <= sel_q;
			out_q.elapsed_out   <= '0;
			out_q.inclusive_out <= a_rdata.incl;
			out_q.exclusive_out <= a_rdata.excl;
			out_q.hits_out      <= a_rdata.hits;
			if (state_q == S_ENT && full) begin
				out_q.status <= ST_OVERFLOW;
			end
			if (state_q == S_X1) begin
				out_q.status     <= ST_EMPTY;
				out_q.anchor_out <= '0;
			end
			if (state_q == S_X3) begin
				out_q.anchor_out    <= fa_q;
				out_q.elapsed_out   <= elapsed_q;
				out_q.inclusive_out <= a_upd.incl;
				out_q.exclusive_out <= a_upd.excl;
				out_q.hits_out      <= a_upd.hits;
			end
		end
	end

	// checks
	`NSTA_ASSERT_NOW(a_no_cmd_in_clear, state_q == S_CLR, !cmd_ready, "command taken during table clear")
	`NSTA_ASSERT_NOW(a_idle_no_write, state_q == S_IDLE, !a_we && !f_we, "table written while idle")
	`NSTA_ASSERT_NEXT(a_overflow_flag, state_q == S_ENT && finish && full, rsp_valid && rsp.status == ST_OVERFLOW, "full-stack enter not flagged")
	`NSTA_ASSERT_NEXT(a_level_step, 1'b1, level_q == $past(level_q) || level_q == $past(level_q) + 1'b1 || level_q == $past(level_q) - 1'b1, "stack level jumped")

endmodule
